// File: sv/lbc_pkg.sv
// Shared types and constants for the multi-channel LED blink controller.
`default_nettype none
package lbc_pkg;

   localparam int unsigned OP_WIDTH      = 2;
   localparam int unsigned ID_WIDTH      = 2;
   localparam int unsigned COUNT_WIDTH   = 8;
   localparam int unsigned TIME_WIDTH    = 16;
   localparam int unsigned PHASE_WIDTH   = TIME_WIDTH + 1;
   localparam int unsigned OUT_CHANNELS  = 4;

   localparam logic [OP_WIDTH-1:0] OP_TICK      = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_SET_FLASH = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_SET_LEVEL = 2'd2;

   // Flash count that means "blink without end".
   localparam logic [COUNT_WIDTH-1:0] FOREVER_COUNT = 8'hFF;

   // Per-channel command decoded from one item.
   typedef struct packed {
      logic tick;
      logic load;
      logic force_level;
      logic clear;
   } cmd_type;

endpackage
`default_nettype wire

// File: sv/lbc_channel.sv
// One blink channel: its stored state and the update applied by one item.
`default_nettype none
module lbc_channel (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                enable,
   input  wire lbc_pkg::cmd_type                    cmd,
   input  wire logic [lbc_pkg::COUNT_WIDTH-1:0]     flash_count,
   input  wire logic [lbc_pkg::TIME_WIDTH-1:0]      on_time,
   input  wire logic [lbc_pkg::TIME_WIDTH-1:0]      dark_time,
   input  wire logic                                level,
   output logic                                     level_next
);

   logic [lbc_pkg::COUNT_WIDTH-1:0] flashes_ff, flashes_in;
   logic [lbc_pkg::TIME_WIDTH-1:0]  on_ff, on_in;
   logic [lbc_pkg::TIME_WIDTH-1:0]  off_ff, off_in;
   logic [lbc_pkg::PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic                            level_ff, level_in;
   logic [lbc_pkg::PHASE_WIDTH-1:0] phase_dec;
   logic [lbc_pkg::PHASE_WIDTH-1:0] reload;

   assign phase_dec = phase_ff - {{(lbc_pkg::PHASE_WIDTH-1){1'b0}}, 1'b1};
   assign reload    = {1'b0, on_ff} + {1'b0, off_ff};

   always_comb begin
      flashes_in = flashes_ff;
      on_in      = on_ff;
      off_in     = off_ff;
      phase_in   = phase_ff;
      level_in   = level_ff;
      if (cmd.tick) begin
         if (phase_ff != '0) begin
            phase_in = phase_dec;
            if (phase_dec == {1'b0, off_ff}) begin
               level_in = 1'b0;
            end
         end else if (flashes_ff == lbc_pkg::FOREVER_COUNT) begin
            level_in = 1'b1;
            phase_in = reload;
         end else if (flashes_ff != '0) begin
            level_in   = 1'b1;
            flashes_in = flashes_ff - {{(lbc_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
            phase_in   = reload;
         end
      end else if (cmd.load) begin
         flashes_in = flash_count;
         on_in      = on_time;
         off_in     = dark_time;
         phase_in   = '0;
         level_in   = 1'b0;
      end else if (cmd.force_level) begin
         level_in = level;
         if (cmd.clear) begin
            flashes_in = '0;
            on_in      = '0;
            off_in     = '0;
            phase_in   = '0;
         end
      end
   end

   assign level_next = level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         flashes_ff <= '0;
         on_ff      <= '0;
         off_ff     <= '0;
         phase_ff   <= '0;
         level_ff   <= 1'b0;
      end else if (enable) begin
         flashes_ff <= flashes_in;
         on_ff      <= on_in;
         off_ff     <= off_in;
         phase_ff   <= phase_in;
         level_ff   <= level_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/multi_led_blink_controller.sv
// Top level of the multi-channel LED blink controller.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   operation, led_id, flash_count,
//                                              on_time, dark_time, level, clear_blink
//   rsp_      out        rsp_valid/rsp_ready   led_levels
//
// Every request transfer yields exactly one response transfer. A request is held
// in the input register; in the cycle it leaves, all channels update and the
// resulting levels load the response register. Throughput is one transfer per
// cycle while rsp_ready holds, set by the single channel update step.
// Reset (synchronous, active high) clears all channel state; all LEDs start off.
// A stalled response holds both registers; req_ready drops only when they are full.
`default_nettype none
module multi_led_blink_controller #(
   parameter int unsigned LED_COUNT = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [lbc_pkg::OP_WIDTH-1:0]        req_operation,
   input  wire logic [lbc_pkg::ID_WIDTH-1:0]        req_led_id,
   input  wire logic [lbc_pkg::COUNT_WIDTH-1:0]     req_flash_count,
   input  wire logic [lbc_pkg::TIME_WIDTH-1:0]      req_on_time,
   input  wire logic [lbc_pkg::TIME_WIDTH-1:0]      req_dark_time,
   input  wire logic                                req_level,
   input  wire logic                                req_clear_blink,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [lbc_pkg::OUT_CHANNELS-1:0]         rsp_led_levels
);

   // Input register.
   logic                                 in_valid_ff;
   logic [lbc_pkg::OP_WIDTH-1:0]         op_ff;
   logic [lbc_pkg::ID_WIDTH-1:0]         id_ff;
   logic [lbc_pkg::COUNT_WIDTH-1:0]      count_ff;
   logic [lbc_pkg::TIME_WIDTH-1:0]       on_ff;
   logic [lbc_pkg::TIME_WIDTH-1:0]       off_ff;
   logic                                 level_ff;
   logic                                 clear_ff;

   // Response register.
   logic                                 rsp_valid_ff;
   logic [lbc_pkg::OUT_CHANNELS-1:0]     rsp_levels_ff, rsp_levels_in;

   logic                                 advance;
   logic                                 is_tick, is_flash, is_level;
   logic [LED_COUNT-1:0]                 level_next;

   // The item in the input register moves on when the response slot is free
   // or is being drained in this cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      is_tick  = 1'b0;
      is_flash = 1'b0;
      is_level = 1'b0;
      unique case (op_ff)
         lbc_pkg::OP_TICK:      is_tick  = 1'b1;
         lbc_pkg::OP_SET_FLASH: is_flash = 1'b1;
         lbc_pkg::OP_SET_LEVEL: is_level = 1'b1;
         default: ;
      endcase
   end

   // One channel per LED. Only the first four can be addressed by led_id,
   // so an id at or beyond LED_COUNT simply matches no channel.
   for (genvar ch = 0; ch < LED_COUNT; ch++) begin : g_chan
      localparam logic [lbc_pkg::ID_WIDTH-1:0] ChId = (lbc_pkg::ID_WIDTH)'(ch);
      logic             hit;
      lbc_pkg::cmd_type cmd;

      assign hit             = (ch < lbc_pkg::OUT_CHANNELS) && (id_ff == ChId);
      assign cmd.tick        = is_tick;
      assign cmd.load        = is_flash && hit;
      assign cmd.force_level = is_level && hit;
      assign cmd.clear       = clear_ff;

      lbc_channel u_chan (
         .clock       (clock),
         .reset       (reset),
         .enable      (advance),
         .cmd         (cmd),
         .flash_count (count_ff),
         .on_time     (on_ff),
         .dark_time   (off_ff),
         .level       (level_ff),
         .level_next  (level_next[ch])
      );
   end

   // Pack the first four levels; missing channels read as off.
   for (genvar i = 0; i < lbc_pkg::OUT_CHANNELS; i++) begin : g_pack
      if (i < LED_COUNT) begin : g_on
         assign rsp_levels_in[i] = level_next[i];
      end else begin : g_off
         assign rsp_levels_in[i] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff    <= req_operation;
         id_ff    <= req_led_id;
         count_ff <= req_flash_count;
         on_ff    <= req_on_time;
         off_ff   <= req_dark_time;
         level_ff <= req_level;
         clear_ff <= req_clear_blink;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_levels_ff <= rsp_levels_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_led_levels = rsp_levels_ff;

endmodule
`default_nettype wire
